[src/lrupr_pkg.sv]
// shared types for the lru page replacement block
package lrupr_pkg;

	// sequencer states, one-hot
	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_SCAN   = 3'b010,
		ST_UPDATE = 3'b100
	} state_t;

	// control from the sequencer into the scan unit
	typedef struct packed {
		logic clear;
		logic vld;
	} scan_ctl_t;

	// what the scan unit has found so far
	typedef struct packed {
		logic hit;
		logic empty;
	} scan_flags_t;

	localparam int unsigned CFG_BITS = 5;
	localparam int unsigned FRAME_IDX_BITS = 4;
	localparam logic [CFG_BITS-1:0] FRAMES_RESET = 5'd3;

endpackage

[src/lru_page_replacement_top.sv]
// top level of the fully associative lru page replacement block
//
// usage: an access (page_number, start_sequence) is taken at a rising edge with
// start high and busy low. busy then stays high until the access is finished.
// start_sequence set clears all frames and both counters before the lookup.
// the frame pages sit in a small ram that is read one frame a cycle; the scan
// unit compares each page against the access and tracks the first empty frame
// and the oldest frame. after the scan, ranks and valid bits of all active
// frames update together and the page is written on a miss.
// an access runs from the accepting edge until busy drops through a scan of the
// n active frames over the single ram read port and its read register, a step
// that drains the scan, and the update.
// the result appears with done high for exactly one cycle as busy
// falls; a new access can be started in that same cycle. the receiver has no
// way to hold results off, so it must take each one when done is high.
// configuration: frames_in_use is written whenever cfg_valid is high
// (cfg_ready is always high); it should only change while busy is low.
// reset clears frames, ranks, counts and sets frames_in_use to 3.
module lru_page_replacement_top #(
	parameter int unsigned FRAME_SLOTS = 16,
	parameter int unsigned PAGE_BITS   = 16,
	parameter int unsigned COUNT_BITS  = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [lrupr_pkg::CFG_BITS-1:0]       cfg_data,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [PAGE_BITS-1:0]                 page_number,
	input  logic                                 start_sequence,
	output logic                                 done,
	output logic                                 hit,
	output logic [lrupr_pkg::FRAME_IDX_BITS-1:0] frame_index,
	output logic                                 evicted_valid,
	output logic [PAGE_BITS-1:0]                 evicted_page,
	output logic [COUNT_BITS-1:0]                hit_count,
	output logic [COUNT_BITS-1:0]                fault_count
);

	import lrupr_pkg::*;

	localparam int unsigned IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
	localparam int unsigned CNT_W = $clog2(FRAME_SLOTS + 1);
	localparam int unsigned CW    = (CNT_W > CFG_BITS) ? CNT_W : CFG_BITS;
	localparam logic [IDX_W-1:0] RANK_MAX = IDX_W'(FRAME_SLOTS - 1);

	state_t               state_q;
	logic [CFG_BITS-1:0]  frames_in_use_q;
	logic [CNT_W-1:0]     n_q;
	logic [CNT_W-1:0]     rd_idx_q;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic                 cmp_vld_s1;
	logic [PAGE_BITS-1:0] page_q;
	logic                 valid_q [FRAME_SLOTS];
	logic [IDX_W-1:0]     rank_q [FRAME_SLOTS];
	logic [COUNT_BITS-1:0] hits_q;
	logic [COUNT_BITS-1:0] faults_q;

	logic                  done_q;
	logic                  hit_q;
	logic [IDX_W-1:0]      sel_q;
	logic                  ev_valid_q;
	logic [PAGE_BITS-1:0]  ev_page_q;

	logic                 accept;
	logic [CW-1:0]        cfg_ext;
	logic [CNT_W-1:0]     n_next;
	logic                 issue;
	scan_ctl_t            scan_ctl;
	scan_flags_t          scan_flags;
	logic [IDX_W-1:0]     hit_sel;
	logic [IDX_W-1:0]     empty_sel;
	logic [IDX_W-1:0]     old_sel;
	logic [IDX_W-1:0]     old_rank;
	logic [PAGE_BITS-1:0] old_page;
	logic [PAGE_BITS-1:0] rdata;
	logic [IDX_W-1:0]     sel_c;
	logic [IDX_W-1:0]     limit_c;
	logic                 all_c;
	logic                 ram_we;
	logic [COUNT_BITS-1:0] hits_inc;
	logic [COUNT_BITS-1:0] faults_inc;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	// active frame count, zero acts as one, clamp to the slots built
	always_comb begin
		cfg_ext = CW'(frames_in_use_q);
		if (cfg_ext == '0) begin
			n_next = CNT_W'(1);
		end else if (cfg_ext > CW'(FRAME_SLOTS)) begin
			n_next = CNT_W'(FRAME_SLOTS);
		end else begin
			n_next = CNT_W'(cfg_ext);
		end
	end

	assign issue        = (state_q == ST_SCAN) && (rd_idx_q < n_q);
	assign scan_ctl.clear = accept;
	assign scan_ctl.vld   = cmp_vld_s1;

	// choice of frame and ageing rule for the update
	always_comb begin
		if (scan_flags.hit) begin
			sel_c   = hit_sel;
			limit_c = rank_q[hit_sel];
			all_c   = 1'b0;
		end else if (scan_flags.empty) begin
			sel_c   = empty_sel;
			limit_c = '0;
			all_c   = 1'b1;
		end else begin
			sel_c   = old_sel;
			limit_c = old_rank;
			all_c   = 1'b0;
		end
	end

	assign ram_we     = (state_q == ST_UPDATE) && !scan_flags.hit;
	assign hits_inc   = (&hits_q) ? hits_q : hits_q + COUNT_BITS'(1);
	assign faults_inc = (&faults_q) ? faults_q : faults_q + COUNT_BITS'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_in_use_q <= FRAMES_RESET;
		end else if (cfg_valid) begin
			frames_in_use_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q     <= (state_q == ST_UPDATE);
			cmp_vld_s1 <= issue;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end else if (!cmp_vld_s1) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			page_q <= page_number;
			n_q    <= n_next;
		end
		cmp_idx_s1 <= rd_idx_q[IDX_W-1:0];
		if (state_q == ST_UPDATE) begin
			hit_q      <= scan_flags.hit;
			sel_q      <= sel_c;
			ev_valid_q <= !scan_flags.hit && !scan_flags.empty;
			ev_page_q  <= (!scan_flags.hit && !scan_flags.empty) ? old_page : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < FRAME_SLOTS; j++) begin
				valid_q[j] <= 1'b0;
				rank_q[j]  <= '0;
			end
			hits_q   <= '0;
			faults_q <= '0;
		end else if (accept && start_sequence) begin
			for (int j = 0; j < FRAME_SLOTS; j++) begin
				valid_q[j] <= 1'b0;
				rank_q[j]  <= '0;
			end
			hits_q   <= '0;
			faults_q <= '0;
		end else if (state_q == ST_UPDATE) begin
			// all active frames update in parallel; only those the ageing rule picks age
			for (int j = 0; j < FRAME_SLOTS; j++) begin
				if (IDX_W'(j) == sel_c) begin
					rank_q[j] <= '0;
				end else if ((CNT_W'(j) < n_q) && valid_q[j] &&
						(all_c || (rank_q[j] < limit_c)) && (rank_q[j] < RANK_MAX)) begin
					rank_q[j] <= rank_q[j] + IDX_W'(1);
				end
			end
			valid_q[sel_c] <= 1'b1;
			if (scan_flags.hit) begin
				hits_q <= hits_inc;
			end else begin
				faults_q <= faults_inc;
			end
		end
	end

	lrupr_ram #(
		.WIDTH (PAGE_BITS),
		.DEPTH (FRAME_SLOTS)
	) u_page_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (sel_c),
		.wdata (page_q),
		.raddr (rd_idx_q[IDX_W-1:0]),
		.rdata (rdata)
	);

	lrupr_scan #(
		.FRAME_SLOTS (FRAME_SLOTS),
		.PAGE_BITS   (PAGE_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (scan_ctl),
		.idx         (cmp_idx_s1),
		.frame_valid (valid_q[cmp_idx_s1]),
		.rank        (rank_q[cmp_idx_s1]),
		.rdata       (rdata),
		.page        (page_q),
		.flags       (scan_flags),
		.hit_sel     (hit_sel),
		.empty_sel   (empty_sel),
		.old_sel     (old_sel),
		.old_rank    (old_rank),
		.old_page    (old_page)
	);

	assign done          = done_q;
	assign hit           = hit_q;
	assign frame_index   = FRAME_IDX_BITS'(sel_q);
	assign evicted_valid = ev_valid_q;
	assign evicted_page  = ev_page_q;
	assign hit_count     = hits_q;
	assign fault_count   = faults_q;

	// a result only follows the update step
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPDATE))
		else $error("result strobe without an update step");

	// an accepted transaction always starts a scan
	a_accept_scans: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (state_q == ST_SCAN))
		else $error("accepted access did not start a scan");

	// an eviction is never reported on a hit
	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(done && evicted_valid) |-> !hit)
		else $error("eviction reported on a hit");

	// the scan never reads past the active frames
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_idx_q <= n_q))
		else $error("scan index beyond active frames");

endmodule

[src/lrupr_ram.sv]
// generic single write port ram with registered read
module lrupr_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

[src/lrupr_scan.sv]
// frame scan unit: match, first empty frame and oldest frame, one frame a cycle
module lrupr_scan #(
	parameter int unsigned FRAME_SLOTS = 16,
	parameter int unsigned PAGE_BITS   = 16
) (
	input  logic                                                     clk,
	input  logic                                                     arst_n,
	input  lrupr_pkg::scan_ctl_t                                     ctl,
	input  logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] idx,
	input  logic                                                     frame_valid,
	input  logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] rank,
	input  logic [PAGE_BITS-1:0]                                     rdata,
	input  logic [PAGE_BITS-1:0]                                     page,
	output lrupr_pkg::scan_flags_t                                   flags,
	output logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] hit_sel,
	output logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] empty_sel,
	output logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] old_sel,
	output logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] old_rank,
	output logic [PAGE_BITS-1:0]                                     old_page
);

	import lrupr_pkg::*;

	localparam int unsigned IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

	scan_flags_t      flags_q;
	logic [IDX_W-1:0] hit_sel_q;
	logic [IDX_W-1:0] empty_sel_q;
	logic [IDX_W-1:0] old_sel_q;
	logic [IDX_W-1:0] old_rank_q;
	logic [PAGE_BITS-1:0] old_page_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q <= '0;
		end else if (ctl.clear) begin
			flags_q <= '0;
		end else if (ctl.vld) begin
			// lowest matching frame wins
			if (frame_valid && (rdata == page) && !flags_q.hit) begin
				flags_q.hit <= 1'b1;
			end
			if (!frame_valid && !flags_q.empty) begin
				flags_q.empty <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.vld) begin
			if (frame_valid && (rdata == page) && !flags_q.hit) begin
				hit_sel_q <= idx;
			end
			if (!frame_valid && !flags_q.empty) begin
				empty_sel_q <= idx;
			end
			// strictly older only, so ties keep the lowest frame
			if ((idx == '0) || (rank > old_rank_q)) begin
				old_rank_q <= rank;
				old_sel_q  <= idx;
				old_page_q <= rdata;
			end
		end
	end

	assign flags     = flags_q;
	assign hit_sel   = hit_sel_q;
	assign empty_sel = empty_sel_q;
	assign old_sel   = old_sel_q;
	assign old_rank  = old_rank_q;
	assign old_page  = old_page_q;

endmodule
